@@ hw/rtl/igc_pkg.sv @@
// Shared types and constants for the gated IoU box cost pipeline.
package igc_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned SIZE_W  = 15;
  localparam int unsigned AREA_W  = 2 * SIZE_W;
  localparam int unsigned UNI_W   = AREA_W + 1;
  localparam int unsigned Q_W     = 16;
  localparam int unsigned FRAC_W  = 15;
  localparam int unsigned NUM_W   = UNI_W + Q_W;

  localparam logic [Q_W-1:0] COST_ONE = 16'h8000;
  localparam logic [Q_W-1:0] COST_INF = 16'hFFFF;

  typedef struct packed {
    logic signed [COORD_W-1:0] track_x;
    logic signed [COORD_W-1:0] track_y;
    logic [SIZE_W-1:0]         track_w;
    logic [SIZE_W-1:0]         track_h;
    logic                      track_stale;
    logic signed [COORD_W-1:0] det_x;
    logic signed [COORD_W-1:0] det_y;
    logic [SIZE_W-1:0]         det_w;
    logic [SIZE_W-1:0]         det_h;
    logic                      row_end;
  } pair_t;

  typedef struct packed {
    logic [Q_W-1:0] cost;
    logic           gated;
    logic           row_last;
  } res_t;

  // Flags that ride alongside the arithmetic.
  typedef struct packed {
    logic stale;
    logic last;
  } side_t;

  // Dividend, divisor and flags handed from geometry to the divider.
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [UNI_W-1:0] den;
    logic             zero;
    side_t            side;
  } div_in_t;

  typedef struct packed {
    logic [Q_W-1:0] q;
    logic           zero;
    side_t          side;
  } div_out_t;

  // One stage of the restoring divider.
  typedef struct packed {
    logic [UNI_W-1:0] rem;
    logic [Q_W-1:0]   num_lo;
    logic [Q_W-1:0]   q;
    logic [UNI_W-1:0] den;
    logic             zero;
    side_t            side;
  } div_stage_t;

endpackage

@@ hw/rtl/igc_geom.sv @@
// Box geometry pipeline: overlap edges, areas, intersection, union, dividend.
module igc_geom (
  input  logic             clk,
  input  logic             rst,
  input  igc_pkg::pair_t   pair,
  input  logic             pair_valid,
  output logic             pair_ready,
  output igc_pkg::div_in_t dout,
  output logic             dout_valid,
  input  logic             dout_ready
);
  import igc_pkg::*;

  localparam int unsigned NSTG = 5;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] rdy;

  // stage 0: overlap edges
  logic signed [COORD_W-1:0] s0_l, s0_t;
  logic signed [COORD_W:0]   s0_r, s0_b;
  logic [SIZE_W-1:0]         s0_tw, s0_th, s0_dw, s0_dh;
  side_t                     s0_side;
  // stage 1: clamped overlap sizes and box areas
  logic [SIZE_W-1:0]         s1_iw, s1_ih;
  logic [AREA_W-1:0]         s1_at, s1_ad;
  side_t                     s1_side;
  // stage 2: intersection and area sum
  logic [AREA_W-1:0]         s2_inter;
  logic [UNI_W-1:0]          s2_asum;
  side_t                     s2_side;
  // stage 3: union
  logic [AREA_W-1:0]         s3_inter;
  logic [UNI_W-1:0]          s3_uni;
  side_t                     s3_side;

  logic signed [COORD_W:0]   tr_r, dt_r, tr_b, dt_b;
  logic signed [COORD_W+1:0] iw_full, ih_full;

  always_comb begin
    rdy[NSTG-1] = !vld[NSTG-1] || dout_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign pair_ready = rdy[0];
  assign dout_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= pair_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_comb begin
    tr_r = $signed({pair.track_x[COORD_W-1], pair.track_x}) + $signed({2'b00, pair.track_w});
    dt_r = $signed({pair.det_x[COORD_W-1], pair.det_x}) + $signed({2'b00, pair.det_w});
    tr_b = $signed({pair.track_y[COORD_W-1], pair.track_y}) + $signed({2'b00, pair.track_h});
    dt_b = $signed({pair.det_y[COORD_W-1], pair.det_y}) + $signed({2'b00, pair.det_h});
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_l    <= (pair.track_x > pair.det_x) ? pair.track_x : pair.det_x;
      s0_t    <= (pair.track_y > pair.det_y) ? pair.track_y : pair.det_y;
      s0_r    <= (tr_r < dt_r) ? tr_r : dt_r;
      s0_b    <= (tr_b < dt_b) ? tr_b : dt_b;
      s0_tw   <= pair.track_w;
      s0_th   <= pair.track_h;
      s0_dw   <= pair.det_w;
      s0_dh   <= pair.det_h;
      s0_side <= '{stale: pair.track_stale, last: pair.row_end};
    end
  end

  // A positive overlap never exceeds the smaller box size, so 15 bits hold it.
  always_comb begin
    iw_full = $signed({s0_r[COORD_W], s0_r}) - $signed({{2{s0_l[COORD_W-1]}}, s0_l});
    ih_full = $signed({s0_b[COORD_W], s0_b}) - $signed({{2{s0_t[COORD_W-1]}}, s0_t});
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_iw   <= iw_full[COORD_W+1] ? '0 : iw_full[SIZE_W-1:0];
      s1_ih   <= ih_full[COORD_W+1] ? '0 : ih_full[SIZE_W-1:0];
      s1_at   <= AREA_W'(s0_tw) * AREA_W'(s0_th);
      s1_ad   <= AREA_W'(s0_dw) * AREA_W'(s0_dh);
      s1_side <= s0_side;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_inter <= AREA_W'(s1_iw) * AREA_W'(s1_ih);
      s2_asum  <= {1'b0, s1_at} + {1'b0, s1_ad};
      s2_side  <= s1_side;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_inter <= s2_inter;
      s3_uni   <= s2_asum - {1'b0, s2_inter};
      s3_side  <= s2_side;
    end
  end

  // Dividend is inter * 2^15 plus half the union, for round half up.
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      dout.num  <= {2'b00, s3_inter, {FRAC_W{1'b0}}}
                 + {{(NUM_W-UNI_W+1){1'b0}}, s3_uni[UNI_W-1:1]};
      dout.den  <= s3_uni;
      dout.zero <= (s3_uni == '0);
      dout.side <= s3_side;
    end
  end

endmodule

@@ hw/rtl/igc_div.sv @@
// Restoring divider, one quotient bit per pipeline stage.
module igc_div (
  input  logic              clk,
  input  logic              rst,
  input  igc_pkg::div_in_t  din,
  input  logic              din_valid,
  output logic              din_ready,
  output igc_pkg::div_out_t dout,
  output logic              dout_valid,
  input  logic              dout_ready
);
  import igc_pkg::*;

  logic [Q_W-1:0] vld;
  logic [Q_W-1:0] rdy;
  div_stage_t     stg [Q_W];
  div_stage_t     head;

  always_comb begin
    rdy[Q_W-1] = !vld[Q_W-1] || dout_ready;
    for (int k = Q_W - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign din_ready  = rdy[0];
  assign dout_valid = vld[Q_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= din_valid;
      end
      for (int k = 1; k < Q_W; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // The quotient fits 16 bits, so the top of the dividend is below the divisor.
  always_comb begin
    head.rem    = din.num[NUM_W-1:Q_W];
    head.num_lo = din.num[Q_W-1:0];
    head.q      = '0;
    head.den    = din.den;
    head.zero   = din.zero;
    head.side   = din.side;
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    div_stage_t       prev;
    logic [UNI_W:0]   trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign prev = head;
    end else begin : g_rest
      assign prev = stg[k-1];
    end

    always_comb begin
      trial = {prev.rem, prev.num_lo[Q_W-1]};
      ge    = (trial >= {1'b0, prev.den});
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        stg[k].rem    <= ge ? UNI_W'(trial - {1'b0, prev.den}) : trial[UNI_W-1:0];
        stg[k].num_lo <= {prev.num_lo[Q_W-2:0], 1'b0};
        stg[k].q      <= {prev.q[Q_W-2:0], ge};
        stg[k].den    <= prev.den;
        stg[k].zero   <= prev.zero;
        stg[k].side   <= prev.side;
      end
    end
  end

  always_comb begin
    dout.q    = stg[Q_W-1].q;
    dout.zero = stg[Q_W-1].zero;
    dout.side = stg[Q_W-1].side;
  end

endmodule

@@ hw/rtl/iou_gated_cost.sv @@
// Top level of the gated IoU box cost pipeline.
//
// Usage: present one track box and one detection box per beat on the pair
// channel (pair_valid / pair_ready, payload pair). Each accepted beat yields
// exactly one beat on the res channel (res_valid / res_ready, payload res)
// holding cost = 1 - IoU in Q1.15 (0x8000 is 1.0), the gated flag and row_last.
// A stale track gives cost 0xFFFF with gated set; a pair whose boxes both have
// zero area gives 0x8000.
// Pipeline: five geometry stages, sixteen divider stages (one quotient
// bit each) and the output register lie between acceptance and res_valid.
// Throughput: one pair per cycle while the res channel does not stall, set
// by the one-bit-per-stage divider.
// Stalls: each stage holds its beat only when the stage after it is full and
// blocked, so bubbles close up and new pairs are still taken while a result
// waits at the output. Nothing is dropped or repeated.
// Reset (rst, synchronous, active high) empties every stage; payload
// registers are not cleared.
module iou_gated_cost (
  input  logic           clk,
  input  logic           rst,
  input  igc_pkg::pair_t pair,
  input  logic           pair_valid,
  output logic           pair_ready,
  output igc_pkg::res_t  res,
  output logic           res_valid,
  input  logic           res_ready
);
  import igc_pkg::*;

  div_in_t  geo_out;
  logic     geo_valid;
  logic     geo_ready;
  div_out_t div_out;
  logic     div_valid;
  logic     div_ready;
  logic     out_ready;
  logic [Q_W-1:0] q_sat;

  // Geometry: edges, areas, intersection, union and dividend.
  igc_geom u_geom (
    .clk        (clk),
    .rst        (rst),
    .pair       (pair),
    .pair_valid (pair_valid),
    .pair_ready (pair_ready),
    .dout       (geo_out),
    .dout_valid (geo_valid),
    .dout_ready (geo_ready)
  );

  // Divider: rounded IoU quotient in Q1.15.
  igc_div u_div (
    .clk        (clk),
    .rst        (rst),
    .din        (geo_out),
    .din_valid  (geo_valid),
    .din_ready  (geo_ready),
    .dout       (div_out),
    .dout_valid (div_valid),
    .dout_ready (div_ready)
  );

  assign out_ready = !res_valid || res_ready;
  assign div_ready = out_ready;

  // Saturate the quotient at 1.0; intersection never exceeds union anyway.
  assign q_sat = (div_out.q > COST_ONE) ? COST_ONE : div_out.q;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_ready) begin
      res_valid <= div_valid;
    end
  end

  // Format the result: stale tracks gate to infinity, empty union costs 1.0.
  always_ff @(posedge clk) begin
    if (out_ready) begin
      res.row_last <= div_out.side.last;
      res.gated    <= div_out.side.stale;
      if (div_out.side.stale) begin
        res.cost <= COST_INF;
      end else if (div_out.zero) begin
        res.cost <= COST_ONE;
      end else begin
        res.cost <= COST_ONE - q_sat;
      end
    end
  end

endmodule

@@ dv/iou_gated_cost_tb.sv @@
// Self-checking testbench for the gated IoU box cost pipeline.
`timescale 1ns / 1ps

module iou_gated_cost_tb;
  import igc_pkg::*;

  localparam int unsigned N_ITEMS    = 1850;
  localparam int unsigned CHOKE_AT   = 500;   // results seen before the long hold-off
  localparam int unsigned CHOKE_LEN  = 300;   // cycles of hold-off, well past the depth
  localparam int unsigned TAIL_CYC   = 40;    // idle cycles after the last result comes back

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  pair_t pair = '0;
  logic  pair_valid = 1'b0;
  logic  pair_ready;
  res_t  res;
  logic  res_valid;
  logic  res_ready = 1'b0;

  iou_gated_cost uut (
    .clk        (clk),
    .rst        (rst),
    .pair       (pair),
    .pair_valid (pair_valid),
    .pair_ready (pair_ready),
    .res        (res),
    .res_valid  (res_valid),
    .res_ready  (res_ready)
  );

  always #5 clk = ~clk;

  // Box pairs waiting to go out, with a flag that holds the pair back until
  // every outstanding cost has come back.
  pair_t pend_q[$];
  bit    hold_q[$];
  // Costs predicted for accepted pairs, oldest first.
  res_t  cost_q[$];

  int unsigned pairs_sent   = 0;
  int unsigned pairs_taken  = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;

  // Predict one result beat: 1 - IoU in Q1.15, or the infinity marker.
  function automatic res_t predict_res(pair_t p);
    res_t   r;
    longint tx, ty, dx, dy, tw, th, dw, dh;
    longint lft, top, rgt, bot, iw, ih, inter, uni, q;
    tx = longint'($signed(p.track_x));
    ty = longint'($signed(p.track_y));
    dx = longint'($signed(p.det_x));
    dy = longint'($signed(p.det_y));
    tw = longint'(p.track_w);
    th = longint'(p.track_h);
    dw = longint'(p.det_w);
    dh = longint'(p.det_h);
    r.row_last = p.row_end;
    r.gated    = 1'b0;
    if (p.track_stale) begin
      r.cost  = COST_INF;
      r.gated = 1'b1;
    end else begin
      lft = (tx > dx) ? tx : dx;
      top = (ty > dy) ? ty : dy;
      rgt = (tx + tw < dx + dw) ? tx + tw : dx + dw;
      bot = (ty + th < dy + dh) ? ty + th : dy + dh;
      iw  = (rgt - lft < 0) ? 0 : rgt - lft;
      ih  = (bot - top < 0) ? 0 : bot - top;
      inter = iw * ih;
      uni   = tw * th + dw * dh - inter;
      if (uni == 0) begin
        // Both boxes empty: report 1.0 instead of a NaN.
        r.cost = COST_ONE;
      end else begin
        q = ((inter << 15) + (uni >> 1)) / uni;
        if (q > 32768) q = 32768;
        r.cost = 16'(32768 - q);
      end
    end
    return r;
  endfunction

  function automatic pair_t mk_pair(int tx, int ty, int tw, int th, bit stale,
                                    int dx, int dy, int dw, int dh, bit last);
    pair_t p;
    p.track_x     = COORD_W'(tx);
    p.track_y     = COORD_W'(ty);
    p.track_w     = SIZE_W'(tw);
    p.track_h     = SIZE_W'(th);
    p.track_stale = stale;
    p.det_x       = COORD_W'(dx);
    p.det_y       = COORD_W'(dy);
    p.det_w       = SIZE_W'(dw);
    p.det_h       = SIZE_W'(dh);
    p.row_end     = last;
    return p;
  endfunction

  // Mostly overlapping pairs so the divider sees real fractions; the rest is
  // full-range noise, stale tracks and empty boxes.
  function automatic pair_t rand_pair();
    pair_t       p;
    int unsigned kind;
    int          span;
    kind = $urandom_range(0, 99);
    p.track_x     = COORD_W'($urandom);
    p.track_y     = COORD_W'($urandom);
    p.track_w     = SIZE_W'($urandom);
    p.track_h     = SIZE_W'($urandom);
    p.det_x       = COORD_W'($urandom);
    p.det_y       = COORD_W'($urandom);
    p.det_w       = SIZE_W'($urandom);
    p.det_h       = SIZE_W'($urandom);
    p.track_stale = 1'b0;
    p.row_end     = ($urandom_range(0, 3) == 0);
    if (kind < 70) begin
      span = ($urandom_range(0, 9) == 0) ? 32767 : ($urandom_range(0, 1) ? 1023 : 63);
      p.track_w = SIZE_W'($urandom_range(0, span));
      p.track_h = SIZE_W'($urandom_range(0, span));
      p.det_w   = SIZE_W'($urandom_range(0, span));
      p.det_h   = SIZE_W'($urandom_range(0, span));
      p.det_x   = COORD_W'($signed(p.track_x) + int'($urandom_range(0, 2 * span)) - span);
      p.det_y   = COORD_W'($signed(p.track_y) + int'($urandom_range(0, 2 * span)) - span);
    end else if (kind < 85) begin
      // leave as drawn: full-range noise
    end else if (kind < 95) begin
      p.track_stale = 1'b1;
    end else begin
      // zero one side of each box to hit the empty-area paths
      if ($urandom_range(0, 1)) p.track_w = '0; else p.track_h = '0;
      if ($urandom_range(0, 1)) p.det_w = '0; else p.det_h = '0;
    end
    return p;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 50) $display("mismatch @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Driver: present one pair per beat, hold it until taken, then idle a drawn
  // number of cycles. Runs of zero gaps come from the burst flag.
  int unsigned send_gap   = 0;
  bit          send_burst = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
    end else if (pair_valid && pairs_taken != pairs_sent) begin
      // hold the beat until the pipeline takes it
    end else if (send_gap > 0) begin
      send_gap--;
      pair_valid <= 1'b0;
    end else if (pend_q.size() != 0 &&
                 !(hold_q[0] && (pairs_taken != pairs_sent || cost_q.size() != 0))) begin
      pair       <= pend_q.pop_front();
      void'(hold_q.pop_front());
      pair_valid <= 1'b1;
      pairs_sent++;
      if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
      send_gap = send_burst ? 0 : $urandom_range(0, 9);
    end else begin
      pair_valid <= 1'b0;
    end
  end

  // Receiver: after each result beat, wait a drawn number of cycles before
  // raising ready again. Once, hold ready low for a long stretch so the
  // pipeline backs up and drops pair_ready.
  int unsigned recv_gap   = 0;
  bit          recv_burst = 1'b0;
  int unsigned seen_last  = 0;
  int unsigned choke_cnt  = 0;
  bit          choke_done = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (results_seen != seen_last) begin
        seen_last = results_seen;
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        recv_gap = recv_burst ? 0 : $urandom_range(0, 9);
      end
      if (!choke_done && results_seen >= CHOKE_AT) begin
        choke_done = 1'b1;
        choke_cnt  = CHOKE_LEN;
      end
      if (choke_cnt > 0) begin
        choke_cnt--;
        res_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on every accepted pair, check every accepted result.
  res_t want;

  always @(posedge clk) begin
    if (!rst) begin
      if (pair_valid && pair_ready) begin
        cost_q = {cost_q, predict_res(pair)};
        pairs_taken++;
      end
      if (res_valid && res_ready) begin
        if (cost_q.size() == 0) begin
          report_mismatch($sformatf("result beat %0d with nothing expected", results_seen));
        end else begin
          want = cost_q.pop_front();
          if (res.cost !== want.cost)
            report_mismatch($sformatf("beat %0d cost %h, expected %h",
                                      results_seen, res.cost, want.cost));
          if (res.gated !== want.gated)
            report_mismatch($sformatf("beat %0d gated %b, expected %b",
                                      results_seen, res.gated, want.gated));
          if (res.row_last !== want.row_last)
            report_mismatch($sformatf("beat %0d row_last %b, expected %b",
                                      results_seen, res.row_last, want.row_last));
        end
        results_seen++;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    // Directed pairs: identical, disjoint, empty, stale, extremes, rounding.
    pend_q = {pend_q, mk_pair(10, 10, 20, 20, 0, 10, 10, 20, 20, 0)};
    pend_q = {pend_q, mk_pair(0, 0, 10, 10, 0, 100, 100, 10, 10, 0)};
    pend_q = {pend_q, mk_pair(5, 5, 0, 0, 0, 5, 5, 0, 0, 1)};
    pend_q = {pend_q, mk_pair(0, 0, 50, 50, 1, 0, 0, 50, 50, 1)};
    pend_q = {pend_q, mk_pair(0, 0, 0, 0, 1, 0, 0, 0, 0, 0)};
    pend_q = {pend_q, mk_pair(32767, 32767, 32767, 32767, 0,
                              32767, 32767, 32767, 32767, 1)};
    pend_q = {pend_q, mk_pair(-32768, -32768, 32767, 32767, 0,
                              32767, 32767, 32767, 32767, 0)};
    pend_q = {pend_q, mk_pair(-32768, -32768, 32767, 32767, 0,
                              -32768, -32768, 32767, 32767, 1)};
    pend_q = {pend_q, mk_pair(0, 0, 100, 100, 0, 25, 25, 50, 50, 0)};
    pend_q = {pend_q, mk_pair(0, 0, 10, 10, 0, 10, 0, 10, 10, 0)};
    pend_q = {pend_q, mk_pair(0, 0, 0, 0, 0, -5, -5, 10, 10, 0)};
    pend_q = {pend_q, mk_pair(3, 3, 0, 100, 0, 3, 3, 0, 100, 1)};
    pend_q = {pend_q, mk_pair(0, 0, 1, 1, 0, 0, 0, 2, 1, 0)};
    pend_q = {pend_q, mk_pair(0, 0, 1, 3, 0, 0, 0, 3, 1, 0)};
    pend_q = {pend_q, mk_pair(-32768, -32768, 32767, 32767, 0,
                              -2, -2, 32767, 32767, 0)};
    pend_q = {pend_q, mk_pair(-100, -50, 60, 40, 1, -80, -30, 60, 40, 0)};
    pend_q = {pend_q, mk_pair(-100, -50, 60, 40, 0, -80, -30, 60, 40, 1)};
    pend_q = {pend_q, mk_pair(-10, -10, 5, 5, 0, -32768, -32768, 32767, 32767, 0)};
    pend_q = {pend_q, mk_pair(-1, -1, 32767, 32767, 0, -1, -1, 32767, 32767, 1)};
    pend_q = {pend_q, mk_pair(32767, -32768, 1, 32767, 0, -32768, 32767, 32767, 1, 0)};
    foreach (pend_q[i]) hold_q = {hold_q, 1'b0};

    // Random pairs; drain the pipeline before the first and again midway.
    for (int i = pend_q.size(); i < N_ITEMS; i++) begin
      pend_q = {pend_q, rand_pair()};
      hold_q = {hold_q, (i == 20 || i == 900)};
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Wait for every pair to be taken, then for every cost to come back.
    while (pend_q.size() != 0 || pairs_taken != pairs_sent) @(posedge clk);
    while (cost_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);

    if (mismatches == 0 && cost_q.size() == 0) begin
      $display("iou_gated_cost_tb: PASS");
    end else begin
      $display("iou_gated_cost_tb: FAIL");
    end
    $finish;
  end

  // Watchdog: the slowest correct run is well under half a millisecond.
  initial begin
    #5_000_000;
    $display("iou_gated_cost_tb: FAIL");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/igc_pkg.sv
hw/rtl/igc_geom.sv
hw/rtl/igc_div.sv
hw/rtl/iou_gated_cost.sv
dv/iou_gated_cost_tb.sv
